[rtl/core/double_ended_queue_assert.svh]
// Assertion macros for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/deq_pkg.sv]
// Shared types and constants of the double-ended queue.
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int REQ_W   = 3;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;

    // Request word: req_type, push_value, zero pad.
    localparam int S_DATA_W = 40;
    // Result word: pop_value, pop_ok, push_dropped, front_value, back_value, count, is_empty.
    localparam int M_DATA_W = 112;

    typedef enum logic [REQ_W-1:0] {
        REQ_QUERY      = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_PUSH_BACK  = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_POP_BACK   = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FILL = 2'b10
    } state_t;

endpackage

`default_nettype wire

[rtl/core/double_ended_queue.sv]
// Bounded double-ended queue: a request is taken in S_IDLE, then its result is
// built in S_FILL once the result register is free; no new request is taken
// until then. Elements live in a single-port-read ring memory with a
// registered read; the front and back elements are cached in registers, and
// a pop fetches the new front or back from the memory in S_FILL.
// A push into a full queue is dropped and flagged in the result; a pop from
// an empty queue returns pop_ok low. No clearing pass is needed after reset.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // req_type[2:0], push_value[34:3], zero[39:35]
    input  wire logic [deq_pkg::S_DATA_W-1:0] s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // pop_value[31:0], pop_ok[32], push_dropped[33], front_value[65:34],
    // back_value[97:66], count[108:98], is_empty[109], zero[111:110]
    output logic      [deq_pkg::M_DATA_W-1:0] m_tdata
);

    import deq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    function automatic logic [VALUE_W-1:0] widen(input logic [DATA_WIDTH-1:0] v);
        return VALUE_W'(signed'(v));
    endfunction

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DATA_WIDTH-1:0] front_reg, front_next;
    logic [DATA_WIDTH-1:0] back_reg, back_next;
    logic [DATA_WIDTH-1:0] popped_reg, popped_next;
    logic                  pop_ok_reg, pop_ok_next;
    logic                  dropped_reg, dropped_next;
    logic                  refresh_front_reg, refresh_front_next;
    logic                  refresh_back_reg, refresh_back_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    req_t                  req;
    logic [DATA_WIDTH-1:0] push_val;
    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  load_out;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic [DATA_WIDTH-1:0] front_eff;
    logic [DATA_WIDTH-1:0] back_eff;
    logic [VALUE_W-1:0]    pop_out;
    logic [VALUE_W-1:0]    front_out;
    logic [VALUE_W-1:0]    back_out;
    logic                  empty_out;

    deq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_val),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign req      = req_t'(s_tdata[REQ_W-1:0]);
    assign push_val = DATA_WIDTH'(signed'(s_tdata[REQ_W +: VALUE_W]));
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    // Request: update indices, write pushes, launch pop reads; S_FILL: cache ends.
    always_comb
    begin
        head_next          = head_reg;
        tail_next          = tail_reg;
        count_next         = count_reg;
        front_next         = front_reg;
        back_next          = back_reg;
        popped_next        = popped_reg;
        pop_ok_next        = pop_ok_reg;
        dropped_next       = dropped_reg;
        refresh_front_next = refresh_front_reg;
        refresh_back_next  = refresh_back_reg;
        wr_en              = 1'b0;
        wr_addr            = step_down(head_reg);
        rd_en              = 1'b0;
        rd_addr            = step_up(head_reg);
        if (accept)
        begin
            pop_ok_next        = 1'b0;
            dropped_next       = 1'b0;
            refresh_front_next = 1'b0;
            refresh_back_next  = 1'b0;
            unique case (req)
                REQ_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = step_down(head_reg);
                        head_next  = step_down(head_reg);
                        count_next = count_reg + 1'b1;
                        front_next = push_val;
                        if (empty)
                        begin
                            back_next = push_val;
                        end
                    end
                end
                REQ_PUSH_BACK:
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = tail_reg;
                        tail_next  = step_up(tail_reg);
                        count_next = count_reg + 1'b1;
                        back_next  = push_val;
                        if (empty)
                        begin
                            front_next = push_val;
                        end
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (!empty)
                    begin
                        pop_ok_next        = 1'b1;
                        popped_next        = front_reg;
                        head_next          = step_up(head_reg);
                        count_next         = count_reg - 1'b1;
                        rd_en              = 1'b1;
                        rd_addr            = step_up(head_reg);
                        refresh_front_next = 1'b1;
                    end
                end
                REQ_POP_BACK:
                begin
                    if (!empty)
                    begin
                        pop_ok_next       = 1'b1;
                        popped_next       = back_reg;
                        tail_next         = step_down(tail_reg);
                        count_next        = count_reg - 1'b1;
                        rd_en             = 1'b1;
                        rd_addr           = step_down(step_down(tail_reg));
                        refresh_back_next = 1'b1;
                    end
                end
                default:
                begin
                    // Query and unknown codes change nothing.
                end
            endcase
        end
        else if (load_out)
        begin
            front_next = front_eff;
            back_next  = back_eff;
        end
    end

    // Result cycle: merge the read data and build the result word.
    assign front_eff = refresh_front_reg ? rd_data : front_reg;
    assign back_eff  = refresh_back_reg ? rd_data : back_reg;
    assign empty_out = (count_reg == '0);
    assign pop_out   = pop_ok_reg ? widen(popped_reg) : '0;
    assign front_out = empty_out ? '0 : widen(front_eff);
    assign back_out  = empty_out ? '0 : widen(back_eff);
    assign load_out  = (state_reg == S_FILL) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (load_out)
                begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, empty_out, COUNT_W'(count_reg), back_out,
                                     front_out, dropped_reg, pop_ok_reg, pop_out};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            head_reg          <= '0;
            tail_reg          <= '0;
            count_reg         <= '0;
            pop_ok_reg        <= 1'b0;
            dropped_reg       <= 1'b0;
            refresh_front_reg <= 1'b0;
            refresh_back_reg  <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            head_reg          <= head_next;
            tail_reg          <= tail_next;
            count_reg         <= count_next;
            pop_ok_reg        <= pop_ok_next;
            dropped_reg       <= dropped_next;
            refresh_front_reg <= refresh_front_next;
            refresh_back_reg  <= refresh_back_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg   <= front_next;
        back_reg    <= back_next;
        popped_reg  <= popped_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`include "double_ended_queue_assert.svh"

    `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "element count above depth")
    `DEQ_ASSERT_NOW(a_empty_ptrs, count_reg == '0, head_reg == tail_reg, "empty queue with apart indices")
    `DEQ_ASSERT_NEXT(a_pop_count, accept && !empty && (req == REQ_POP_FRONT || req == REQ_POP_BACK), count_reg == $past(count_reg) - 1'b1, "successful pop did not decrement count")
    `DEQ_ASSERT_NOW(a_one_access, 1'b1, !(wr_en && rd_en), "memory written and read in one cycle")

endmodule

`default_nettype wire

[rtl/core/deq_ram.sv]
// Ring store of the double-ended queue: one write port, one registered read port.
`default_nettype none

module deq_ram #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    parameter int IDX_W      = $clog2(DEPTH)
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [IDX_W-1:0]      wr_addr,
    input  wire logic [DATA_WIDTH-1:0] wr_data,
    input  wire logic                  rd_en,
    input  wire logic [IDX_W-1:0]      rd_addr,
    output logic      [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the read data until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
